FILE: sv/fifo_lifo_queue_with_sort_macros.svh
`ifndef FIFO_LIFO_QUEUE_WITH_SORT_MACROS_SVH
`define FIFO_LIFO_QUEUE_WITH_SORT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define FLQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define FLQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/flqs_pkg.sv
package flqs_pkg;

  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int IO_VALUE_W   = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LIFO_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SORT_DESC   = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SORT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_CMP,
    ST_WB,
    ST_DONE
  } state_t;

endpackage

FILE: sv/flqs_if.sv
interface flqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [flqs_pkg::CMD_W-1:0]          cmd;
  logic [flqs_pkg::IO_VALUE_W-1:0]     push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface flqs_out_if;
  logic                                valid;
  logic                                ready;
  logic [flqs_pkg::STATUS_W-1:0]       status;
  logic [flqs_pkg::IO_VALUE_W-1:0]     pop_value;
  logic [flqs_pkg::COUNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output status, output pop_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input entry_count,
                  output ready);
endinterface

interface flqs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [flqs_pkg::CFG_INDEX_W-1:0]    index;
  logic [flqs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/fifo_lifo_queue_with_sort.sv
// channel  dir  payload                           transfer
// in_if    in   cmd, push_value                   valid & ready
// out_if   out  status, pop_value, entry_count    valid & ready
// cfg_if   in   index, data                       valid & ready (ready always high)
//
// push, pop and clear may follow back to back while out_if is not stalled
// pop data comes from the element memory in the cycle after the transfer
// sort of n > 1 elements holds in_if.ready low until it ends, with at most
//   one memory read and one memory write per cycle, and waits for any pending result
// synchronous active-low reset clears pointers, count, mode bits and valids, not the memory
// a stalled out_if holds one result in a stage and one in the output register
`include "fifo_lifo_queue_with_sort_macros.svh"

module fifo_lifo_queue_with_sort #(
  parameter int DEPTH        = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  flqs_in_if.sink           in_if,
  flqs_out_if.source        out_if,
  flqs_cfg_if.sink          cfg_if
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CW1    = CNT_W + 1;

  logic [ELEMENT_BITS-1:0] mem [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_r;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ELEMENT_BITS-1:0] wr_data;

  flqs_pkg::state_t        state_r, state_nxt;
  logic [ADDR_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt;
  logic [ELEMENT_BITS-1:0] cur_r, cur_nxt;
  logic                    lifo_r, desc_r;

  logic                    s1_valid_r;
  flqs_pkg::status_t       s1_status_r, s1_status_nxt;
  logic                    s1_pop_r, s1_pop_nxt;
  logic [flqs_pkg::COUNT_OUT_W-1:0] s1_count_r;
  logic                    s1_load, s1_adv, s1_free;

  logic                    out_valid_r;
  logic [flqs_pkg::STATUS_W-1:0]    out_status_r;
  logic [flqs_pkg::IO_VALUE_W-1:0]  out_pop_r;
  logic [flqs_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic                    acc;
  logic                    full, empty, swap_hit;
  logic [ADDR_W-1:0]       head_dec, head_inc;

  function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CW1-1:0] s;
    s = CW1'(base) + CW1'(off);
    if (s >= CW1'(DEPTH)) begin
      s = s - CW1'(DEPTH);
    end
    return ADDR_W'(s);
  endfunction

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_if.ready);
  assign s1_free = !s1_valid_r || s1_adv;
  assign in_if.ready = (state_r == flqs_pkg::ST_IDLE) && s1_free;
  assign acc = in_if.valid && in_if.ready;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign swap_hit = desc_r ? (rd_r > cur_r) : (rd_r < cur_r);

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifo_r <= 1'b0;
      desc_r <= 1'b0;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == flqs_pkg::CFG_LIFO_MODE) begin
        lifo_r <= cfg_if.data[0];
      end else if (cfg_if.index == flqs_pkg::CFG_SORT_DESC) begin
        desc_r <= cfg_if.data[0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = cur_r;
    s1_load       = 1'b0;
    s1_status_nxt = flqs_pkg::STAT_DONE;
    s1_pop_nxt    = 1'b0;
    case (state_r)
      flqs_pkg::ST_IDLE: begin
        if (acc) begin
          case (flqs_pkg::cmd_t'(in_if.cmd))
            flqs_pkg::CMD_PUSH: begin
              s1_load = 1'b1;
              if (full) begin
                s1_status_nxt = flqs_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_data   = ELEMENT_BITS'(in_if.push_value);
                count_nxt = count_r + 1'b1;
                if (lifo_r) begin
                  head_nxt = head_dec;
                  wr_addr  = head_dec;
                end else begin
                  wr_addr = ring_pos(head_r, count_r);
                end
              end
            end
            flqs_pkg::CMD_POP: begin
              s1_load = 1'b1;
              if (empty) begin
                s1_status_nxt = flqs_pkg::STAT_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head_r;
                head_nxt   = head_inc;
                count_nxt  = count_r - 1'b1;
                s1_pop_nxt = 1'b1;
              end
            end
            flqs_pkg::CMD_CLEAR: begin
              s1_load   = 1'b1;
              count_nxt = '0;
              head_nxt  = '0;
            end
            default: begin
              if (count_r > CNT_W'(1)) begin
                i_nxt     = '0;
                state_nxt = flqs_pkg::ST_LOAD;
              end else begin
                s1_load = 1'b1;
              end
            end
          endcase
        end
      end
      flqs_pkg::ST_LOAD: begin
        // read data register is shared with a pending pop result
        if (!s1_valid_r) begin
          rd_en     = 1'b1;
          rd_addr   = ring_pos(head_r, i_r);
          state_nxt = flqs_pkg::ST_FETCH;
        end
      end
      flqs_pkg::ST_FETCH: begin
        cur_nxt   = rd_r;
        j_nxt     = i_r + 1'b1;
        rd_en     = 1'b1;
        rd_addr   = ring_pos(head_r, i_r + 1'b1);
        state_nxt = flqs_pkg::ST_CMP;
      end
      flqs_pkg::ST_CMP: begin
        if (swap_hit) begin
          wr_en   = 1'b1;
          wr_addr = ring_pos(head_r, j_r);
          wr_data = cur_r;
          cur_nxt = rd_r;
        end
        if (CW1'(j_r) + CW1'(1) < CW1'(count_r)) begin
          j_nxt   = j_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = ring_pos(head_r, j_r + 1'b1);
        end else begin
          state_nxt = flqs_pkg::ST_WB;
        end
      end
      flqs_pkg::ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = ring_pos(head_r, i_r);
        wr_data = cur_r;
        if (CW1'(i_r) + CW1'(2) < CW1'(count_r)) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = flqs_pkg::ST_LOAD;
        end else begin
          state_nxt = flqs_pkg::ST_DONE;
        end
      end
      flqs_pkg::ST_DONE: begin
        if (s1_free) begin
          s1_load   = 1'b1;
          state_nxt = flqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = flqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flqs_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_status_r <= s1_status_nxt;
      s1_pop_r    <= s1_pop_nxt;
      s1_count_r  <= flqs_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_pop_r    <= s1_pop_r ? flqs_pkg::IO_VALUE_W'(rd_r) : '0;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.pop_value   = out_pop_r;
  assign out_if.entry_count = out_count_r;

  `FLQS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `FLQS_ASSERT_NOW(a_sort_blocks_in, state_r != flqs_pkg::ST_IDLE, !in_if.ready, "input open during sort")
  `FLQS_ASSERT_NEXT(a_sort_keeps_count, state_r != flqs_pkg::ST_IDLE, count_r == $past(count_r), "count changed during sort")
  `FLQS_ASSERT_NOW(a_scan_in_range, state_r == flqs_pkg::ST_CMP, (j_r < count_r) && (i_r < j_r), "sort index out of range")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import flqs_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 21;
  localparam int HOLD_CYCLES = 80;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

  typedef struct {
    status_t                  status;
    logic [IO_VALUE_W-1:0]    pop_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } queue_result_t;

  class queue_scoreboard;
    logic [IO_VALUE_W-1:0]  store [QUEUE_DEPTH];
    logic [3:0]             head;
    logic [4:0]             count;
    bit                     lifo;
    bit                     descending;
    queue_result_t          expected_results[$];
    int                     errors;

    function new();
      foreach (store[i]) store[i] = '0;
      head = '0;
      count = '0;
      lifo = 0;
      descending = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_LIFO_MODE: lifo = data[0];
        CFG_SORT_DESC: descending = data[0];
        default: ;
      endcase
    endfunction

    function void predict_command(cmd_t cmd, logic [IO_VALUE_W-1:0] value);
      queue_result_t r;
      logic [3:0] pi;
      logic [3:0] pj;
      logic [IO_VALUE_W-1:0] a;
      logic [IO_VALUE_W-1:0] b;
      bit swap;
      r.status = STAT_DONE;
      r.pop_value = '0;
      case (cmd)
        CMD_PUSH: begin
          if (count == QUEUE_DEPTH) begin
            r.status = STAT_FULL;
          end else if (lifo) begin
            head = head - 4'd1;
            store[head] = value;
            count = count + 5'd1;
          end else begin
            pj = head + count[3:0];
            store[pj] = value;
            count = count + 5'd1;
          end
        end
        CMD_POP: begin
          if (count == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.pop_value = store[head];
            head = head + 4'd1;
            count = count - 5'd1;
          end
        end
        CMD_CLEAR: begin
          count = '0;
          head = '0;
        end
        default: begin
          for (int i = 0; i < count; i++) begin
            for (int j = i + 1; j < count; j++) begin
              pi = head + 4'(i);
              pj = head + 4'(j);
              a = store[pj];
              b = store[pi];
              swap = descending ? (a > b) : (a < b);
              if (swap) begin
                store[pj] = b;
                store[pi] = a;
              end
            end
          end
        end
      endcase
      r.entry_count = count;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [IO_VALUE_W-1:0] pop_value,
                               logic [COUNT_OUT_W-1:0] entry_count);
      queue_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d pop_value=%h entry_count=%0d",
                 $time, status, pop_value, entry_count);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (status !== r.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, r.status, status);
        errors++;
      end
      if (pop_value !== r.pop_value) begin
        $display("%0t: pop_value mismatch expected=%h actual=%h", $time, r.pop_value, pop_value);
        errors++;
      end
      if (entry_count !== r.entry_count) begin
        $display("%0t: entry_count mismatch expected=%0d actual=%0d", $time, r.entry_count,
                 entry_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  flqs_in_if  in_bus();
  flqs_out_if out_bus();
  flqs_cfg_if cfg_bus();

  queue_scoreboard board = new();
  bit no_idle;
  bit hold_request;
  int hold_left;
  int cycles;

  fifo_lifo_queue_with_sort #(
    .DEPTH(QUEUE_DEPTH),
    .ELEMENT_BITS(32)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side, with random stalls and one long hold-off
  initial begin
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        board.check_result(out_bus.status, out_bus.pop_value, out_bus.entry_count);
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic drive_command(cmd_t cmd, logic [IO_VALUE_W-1:0] value);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.push_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.predict_command(cmd, value);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    board.write_reg(index, data);
  endtask

  task automatic set_mode(bit lifo, bit descending, bit with_unused);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    write_reg(CFG_LIFO_MODE, {31'($urandom_range(0, 32'h7fff_ffff)), lifo});
    write_reg(CFG_SORT_DESC, {31'($urandom_range(0, 32'h7fff_ffff)), descending});
    if (with_unused) begin
      write_reg(CFG_UNUSED_LO, $urandom);
      write_reg(CFG_UNUSED_HI, $urandom);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [IO_VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom;
    if (sel < 8) return $urandom_range(0, 7);
    if (sel == 8) return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    return 32'h1 << $urandom_range(0, 31);
  endfunction

  task automatic run_random(int n_items, int push_pct);
    int r;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) drive_command(CMD_CLEAR, $urandom);
      else if (r < 10) drive_command(CMD_SORT, $urandom);
      else if (r < 10 + push_pct * 90 / 100) drive_command(CMD_PUSH, pick_value());
      else drive_command(CMD_POP, $urandom);
    end
  endtask

  initial begin
    int push_pct;
    no_idle = 0;
    hold_request = 0;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.cmd <= CMD_PUSH;
    in_bus.push_value <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_LIFO_MODE;
    cfg_bus.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty, single element, small sort, clear, fill to full, push when full, full sort
    drive_command(CMD_POP, 32'h0);
    drive_command(CMD_SORT, 32'h0);
    drive_command(CMD_PUSH, 32'hffff_ffff);
    drive_command(CMD_SORT, 32'h0);
    drive_command(CMD_PUSH, 32'h0);
    drive_command(CMD_PUSH, 32'h1);
    drive_command(CMD_SORT, 32'h0);
    drive_command(CMD_POP, 32'h0);
    drive_command(CMD_CLEAR, 32'h0);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      drive_command(CMD_PUSH, (i == 0) ? 32'hffff_ffff : (i == 15) ? 32'h0 : $urandom);
    end
    drive_command(CMD_PUSH, 32'h1234_5678);
    drive_command(CMD_SORT, 32'h0);

    for (int p = 0; p < 10; p++) begin
      if (p < 4) set_mode(p[0], p[1], p == 1);
      else set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p == 7);
      push_pct = (p % 3 == 0) ? 75 : (p % 3 == 1) ? 30 : 55;
      no_idle = (p == 5);
      if (p == 3) hold_request = 1;
      run_random(123, push_pct);
    end
    in_bus.valid <= 1'b0;
    no_idle = 0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
